>>> hdl/pisa_pkg.sv
// Shared types and constants of the process id and slot allocator.
// Holds the function codes, field widths and the controller/datapath interface.
// No dependencies.
package pisa_pkg;

	localparam int FUNC_W = 2;
	localparam int SLOT_W = 6;
	localparam int ID_W   = 31;
	localparam int LANES  = 16;
	localparam int LANE_W = 4;
	localparam int ADDR_SLOTS = 64;

	localparam logic [FUNC_W-1:0] FN_ALLOC   = 2'd0;
	localparam logic [FUNC_W-1:0] FN_COMMIT  = 2'd1;
	localparam logic [FUNC_W-1:0] FN_RELEASE = 2'd2;

	localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADVANCE,
		ST_SCAN,
		ST_CHECK,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic accept;
		logic advance;
		logic scan;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic in_alloc;
		logic last_row;
		logic hit;
		logic out_free;
	} sts_t;

endpackage

>>> hdl/pisa_ctrl.sv
// Controller of the allocator: sequences accept, id advance, table scan and result.
// Depends on pisa_pkg for the state type and the command and status structs.
module pisa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  pisa_pkg::sts_t   sts,
	output pisa_pkg::cmd_t   cmd
);

	pisa_pkg::state_t state_q;
	pisa_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pisa_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		s_tready  = 1'b0;
		case (state_q)
			pisa_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_nxt  = sts.in_alloc ? pisa_pkg::ST_ADVANCE : pisa_pkg::ST_FINISH;
				end
			end
			pisa_pkg::ST_ADVANCE: begin
				cmd.advance = 1'b1;
				state_nxt   = pisa_pkg::ST_SCAN;
			end
			pisa_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.last_row) begin
					state_nxt = pisa_pkg::ST_CHECK;
				end
			end
			pisa_pkg::ST_CHECK: begin
				state_nxt = sts.hit ? pisa_pkg::ST_ADVANCE : pisa_pkg::ST_FINISH;
			end
			pisa_pkg::ST_FINISH: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_nxt  = pisa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = pisa_pkg::ST_IDLE;
			end
		endcase
	end

	a_finish_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> sts.out_free)
		else $error("result loaded while output register is occupied");

	a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> !s_tready)
		else $error("second transaction taken while an item is in work");

	a_free_id_finishes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pisa_pkg::ST_CHECK && !sts.hit) |=> state_q == pisa_pkg::ST_FINISH)
		else $error("unused id did not lead to a result");

endmodule

>>> hdl/pisa_dpath.sv
// Datapath of the allocator: id counter, slot valid flags, owner id memory,
// row scan compare, free slot search and the output register. Uses pisa_pkg.
module pisa_dpath #(
	parameter int SLOTS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [pisa_pkg::FUNC_W-1:0]   in_func,
	input  logic [pisa_pkg::SLOT_W-1:0]   in_slot,
	input  pisa_pkg::cmd_t                cmd,
	output pisa_pkg::sts_t                sts,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic                          out_status,
	output logic [pisa_pkg::SLOT_W-1:0]   out_slot_found,
	output logic [pisa_pkg::ID_W-1:0]     out_new_id
);

	localparam int EFF  = (SLOTS < pisa_pkg::ADDR_SLOTS) ? SLOTS : pisa_pkg::ADDR_SLOTS;
	localparam int ROWS = (EFF + pisa_pkg::LANES - 1) / pisa_pkg::LANES;
	localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

	logic [pisa_pkg::FUNC_W-1:0]              func_q;
	logic [pisa_pkg::SLOT_W-1:0]              slot_q;
	logic [pisa_pkg::ID_W-1:0]                last_id_q;
	logic [pisa_pkg::LANES-1:0]               valid_q [ROWS];
	logic [pisa_pkg::LANES-1:0][pisa_pkg::ID_W-1:0] owner_mem [ROWS];
	logic [pisa_pkg::LANES-1:0][pisa_pkg::ID_W-1:0] rd_s1;
	logic [pisa_pkg::LANES-1:0]               vrow_s1;
	logic                                     cmp_s1;
	logic [RW-1:0]                            scan_row_q;
	logic                                     hit_q;
	logic                                     out_valid_q;
	logic                                     status_q;
	logic [pisa_pkg::SLOT_W-1:0]              found_q;
	logic [pisa_pkg::ID_W-1:0]                id_q;

	logic                                     match_now;
	logic                                     free_any;
	logic [pisa_pkg::SLOT_W-1:0]              free_idx;
	logic                                     in_range;
	logic [RW-1:0]                            slot_row;
	logic [pisa_pkg::LANE_W-1:0]              slot_lane;
	logic                                     is_alloc;
	logic                                     res_status;
	logic [pisa_pkg::SLOT_W-1:0]              res_found;
	logic [pisa_pkg::ID_W-1:0]                next_id;
	logic                                     last_row;

	assign is_alloc  = (func_q == pisa_pkg::FN_ALLOC);
	assign in_range  = int'(slot_q) < SLOTS;
	assign slot_row  = RW'(slot_q >> pisa_pkg::LANE_W);
	assign slot_lane = slot_q[pisa_pkg::LANE_W-1:0];
	assign next_id   = (last_id_q == pisa_pkg::ID_MAX) ? pisa_pkg::ID_W'(1) : last_id_q + 1'b1;
	assign last_row  = (scan_row_q == RW'(ROWS - 1));

	always_comb begin
		match_now = 1'b0;
		for (int l = 0; l < pisa_pkg::LANES; l++) begin
			if (vrow_s1[l] && rd_s1[l] == last_id_q) begin
				match_now = cmp_s1;
			end
		end
	end

	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int r = ROWS - 1; r >= 0; r--) begin
			for (int l = pisa_pkg::LANES - 1; l >= 0; l--) begin
				if (r * pisa_pkg::LANES + l >= 1 && r * pisa_pkg::LANES + l < EFF
						&& !valid_q[r][l]) begin
					free_any = 1'b1;
					free_idx = pisa_pkg::SLOT_W'(r * pisa_pkg::LANES + l);
				end
			end
		end
	end

	always_comb begin
		res_status = 1'b0;
		res_found  = '0;
		if (is_alloc) begin
			res_status = !free_any;
			res_found  = free_any ? free_idx : '0;
		end else if (func_q == pisa_pkg::FN_COMMIT || func_q == pisa_pkg::FN_RELEASE) begin
			res_status = !in_range;
		end
	end

	always_comb begin
		sts.in_alloc = (in_func == pisa_pkg::FN_ALLOC);
		sts.last_row = last_row;
		sts.hit      = hit_q || match_now;
		sts.out_free = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q <= in_func;
			slot_q <= in_slot;
		end
		if (cmd.scan) begin
			rd_s1   <= owner_mem[scan_row_q];
			vrow_s1 <= valid_q[scan_row_q];
		end
		if (cmd.finish && func_q == pisa_pkg::FN_COMMIT && in_range) begin
			owner_mem[slot_row][slot_lane] <= last_id_q;
		end
		if (cmd.finish) begin
			status_q <= res_status;
			found_q  <= res_found;
			id_q     <= last_id_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_id_q   <= '0;
			cmp_s1      <= 1'b0;
			scan_row_q  <= '0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
			for (int r = 0; r < ROWS; r++) begin
				valid_q[r] <= '0;
			end
		end else begin
			cmp_s1 <= cmd.scan;
			if (cmd.advance) begin
				last_id_q  <= next_id;
				scan_row_q <= '0;
				hit_q      <= 1'b0;
			end else begin
				if (cmd.scan && !last_row) begin
					scan_row_q <= scan_row_q + 1'b1;
				end
				if (match_now) begin
					hit_q <= 1'b1;
				end
			end
			if (cmd.finish && in_range) begin
				if (func_q == pisa_pkg::FN_COMMIT) begin
					valid_q[slot_row][slot_lane] <= 1'b1;
				end else if (func_q == pisa_pkg::FN_RELEASE) begin
					valid_q[slot_row][slot_lane] <= 1'b0;
				end
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign out_status     = status_q;
	assign out_slot_found = found_q;
	assign out_new_id     = id_q;

	a_alloc_id_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && is_alloc) |=> (id_q != '0))
		else $error("allocate produced id zero");

	a_alloc_status_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && is_alloc) |=> (status_q == (found_q == '0)))
		else $error("allocate status disagrees with slot found");

	a_scan_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> (int'(scan_row_q) < ROWS))
		else $error("scan row beyond table");

endmodule

>>> hdl/process_id_and_slot_allocator_unit.sv
// Top level of the process id and slot allocator.
// Instantiates pisa_ctrl and pisa_dpath; types and constants from pisa_pkg.
//
// channel  dir  payload
// s_*      in   tuser[1:0] func ; tdata[5:0] slot
// m_*      out  tuser[0] status ; tdata[5:0] slot_found, tdata[36:6] new_id
//
// Commit, release and unused codes: after the transaction FINISH loads the result register
// once the output is free, and the FSM returns to IDLE to take the next transaction.
// Allocate: for each id tried, ADVANCE, then SCAN over ceil(min(SLOTS,64)/16) rows
// (one row of 16 owner ids read from memory per cycle), then CHECK; then FINISH loads
// the result; ids tried are at most the number of valid slots plus one.
// Reset clears the id counter and all slot valid flags at once; no sweep.
// A held result stalls only the final step; no new item is taken until the FSM is back in IDLE.
module process_id_and_slot_allocator_unit #(
	parameter int SLOTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [5:0] slot, [7:6] zero
	input  logic [1:0]  s_tuser,   // [1:0] func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [5:0] slot_found, [36:6] new_id, [39:37] zero
	output logic [0:0]  m_tuser    // [0] status
);

	pisa_pkg::cmd_t                    cmd;
	pisa_pkg::sts_t                    sts;
	logic                              status;
	logic [pisa_pkg::SLOT_W-1:0]       slot_found;
	logic [pisa_pkg::ID_W-1:0]         new_id;

	pisa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pisa_dpath #(
		.SLOTS (SLOTS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_func        (s_tuser),
		.in_slot        (s_tdata[pisa_pkg::SLOT_W-1:0]),
		.cmd            (cmd),
		.sts            (sts),
		.out_ready      (m_tready),
		.out_valid      (m_tvalid),
		.out_status     (status),
		.out_slot_found (slot_found),
		.out_new_id     (new_id)
	);

	assign m_tdata = {3'b000, new_id, slot_found};
	assign m_tuser = status;

endmodule

>>> tb/pisa_result_checker.sv
// Result checker for the process id and slot allocator testbench.
// Watches both stream channels, predicts every result and compares it; uses pisa_pkg.
module pisa_result_checker #(
	parameter int SLOTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,
	input  logic [0:0]  m_tuser,
	output int          errors,
	output int          pending,
	output int          results_seen,
	output int          allocs_seen,
	output int          full_misses
);
	timeunit 1ns;
	timeprecision 1ps;

	import pisa_pkg::*;

	localparam int REACH = (SLOTS < ADDR_SLOTS) ? SLOTS : ADDR_SLOTS;

	typedef struct packed {
		logic              status;
		logic [SLOT_W-1:0] slot_found;
		logic [ID_W-1:0]   new_id;
	} pid_result_t;

	logic [ID_W-1:0] cur_pid;
	logic            slot_busy [SLOTS];
	logic [ID_W-1:0] slot_pid  [SLOTS];
	pid_result_t     pid_results_due [$];

	function automatic logic [ID_W-1:0] next_pid(input logic [ID_W-1:0] id);
		if (id == ID_MAX)
			return ID_W'(1);
		return id + 1'b1;
	endfunction

	function automatic bit pid_taken(input logic [ID_W-1:0] id);
		bit hit;
		hit = 0;
		for (int k = 0; k < SLOTS; k++)
			if (slot_busy[k] && slot_pid[k] == id)
				hit = 1;
		return hit;
	endfunction

	function automatic pid_result_t predict_pid(input logic [FUNC_W-1:0] fn,
			input logic [SLOT_W-1:0] sl);
		pid_result_t r;
		int guard;
		bit got;
		r = '0;
		got = 0;
		case (fn)
			FN_ALLOC: begin
				cur_pid = next_pid(cur_pid);
				guard = 0;
				while (guard <= SLOTS && pid_taken(cur_pid)) begin
					cur_pid = next_pid(cur_pid);
					guard++;
				end
				r.status = 1'b1;
				for (int k = 1; k < REACH; k++) begin
					if (!got && !slot_busy[k]) begin
						got = 1;
						r.slot_found = SLOT_W'(k);
						r.status = 1'b0;
					end
				end
			end
			FN_COMMIT, FN_RELEASE: begin
				if (int'(sl) >= SLOTS) begin
					r.status = 1'b1;
				end else if (fn == FN_COMMIT) begin
					slot_busy[sl] = 1'b1;
					slot_pid[sl] = cur_pid;
				end else begin
					slot_busy[sl] = 1'b0;
				end
			end
			default: ;
		endcase
		r.new_id = cur_pid;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pid_result_t want;
		pid_result_t got_r;
		if (!arst_n) begin
			cur_pid = '0;
			for (int k = 0; k < SLOTS; k++) begin
				slot_busy[k] = 1'b0;
				slot_pid[k] = '0;
			end
			pid_results_due.delete();
			errors = 0;
			results_seen = 0;
			allocs_seen = 0;
			full_misses = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_r.status = m_tuser[0];
				got_r.slot_found = m_tdata[5:0];
				got_r.new_id = m_tdata[36:6];
				results_seen++;
				if (pid_results_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected result status=%0d slot_found=%0d new_id=%0d",
						$time, got_r.status, got_r.slot_found, got_r.new_id);
				end else begin
					want = pid_results_due.pop_front();
					if (got_r.status != want.status) begin
						errors++;
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, got_r.status);
					end
					if (got_r.slot_found != want.slot_found) begin
						errors++;
						$display("%0t: slot_found expected %0d actual %0d",
							$time, want.slot_found, got_r.slot_found);
					end
					if (got_r.new_id != want.new_id) begin
						errors++;
						$display("%0t: new_id expected %0d actual %0d",
							$time, want.new_id, got_r.new_id);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				want = predict_pid(s_tuser, s_tdata[5:0]);
				if (s_tuser == FN_ALLOC) begin
					allocs_seen++;
					if (want.status)
						full_misses++;
				end
				pid_results_due.push_back(want);
			end
		end
		pending = pid_results_due.size();
	end

endmodule

>>> tb/process_id_and_slot_allocator_unit_tb.sv
// Top of the process id and slot allocator testbench: clock, reset, stimulus and verdict.
// Instantiates process_id_and_slot_allocator_unit and pisa_result_checker; uses pisa_pkg.
module process_id_and_slot_allocator_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pisa_pkg::*;

	localparam int SLOTS = 64;
	localparam logic [FUNC_W-1:0] FN_NONE = 2'd3;
	localparam int TOTAL_ITEMS = 1200;
	localparam int QUIET_AFTER = 1080;
	localparam int LONG_HOLD = 300;
	localparam int STALL_LIMIT = 4000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic [0:0]  m_tuser;

	int errors;
	int pending;
	int results_seen;
	int allocs_seen;
	int full_misses;
	int n_sent;
	int stall_cycles;
	bit quiet;
	bit hold_long;

	process_id_and_slot_allocator_unit #(.SLOTS(SLOTS)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	pisa_result_checker #(.SLOTS(SLOTS)) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.errors       (errors),
		.pending      (pending),
		.results_seen (results_seen),
		.allocs_seen  (allocs_seen),
		.full_misses  (full_misses)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic rest_sender(input int n);
		repeat (n) begin
			@(negedge clk);
			s_tvalid = 1'b0;
			s_tuser = 2'($urandom_range(0, 3));
			s_tdata = 8'($urandom_range(0, 255));
		end
	endtask

	task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [SLOT_W-1:0] sl);
		if (!quiet && $urandom_range(0, 6) == 0)
			rest_sender($urandom_range(1, 7));
		@(negedge clk);
		s_tuser = fn;
		s_tdata = {2'b00, sl};
		s_tvalid = 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		n_sent++;
		if (n_sent >= QUIET_AFTER)
			quiet = 1'b1;
	endtask

	function automatic logic [SLOT_W-1:0] any_slot();
		return SLOT_W'($urandom_range(0, 63));
	endfunction

	task automatic fill_sweep();
		int start;
		start = $urandom_range(0, 63);
		for (int i = 0; i < 64; i++) begin
			if ($urandom_range(0, 9) < 4)
				send_item(FN_ALLOC, any_slot());
			send_item(FN_COMMIT, SLOT_W'((start + i) % 64));
		end
		repeat ($urandom_range(2, 4))
			send_item(FN_ALLOC, any_slot());
	endtask

	task automatic mixed_run();
		int r;
		repeat (80) begin
			r = $urandom_range(0, 99);
			if (r < 35) begin
				send_item(FN_ALLOC, any_slot());
				if ($urandom_range(0, 9) < 7)
					send_item(FN_COMMIT, any_slot());
			end else if (r < 60) begin
				send_item(FN_COMMIT, any_slot());
			end else if (r < 90) begin
				send_item(FN_RELEASE, any_slot());
			end else begin
				send_item(FN_NONE, any_slot());
			end
		end
	endtask

	task automatic drain_run();
		int r;
		repeat (60) begin
			r = $urandom_range(0, 99);
			if (r < 55)
				send_item(FN_RELEASE, any_slot());
			else if (r < 85)
				send_item(FN_ALLOC, any_slot());
			else
				send_item(FN_COMMIT, any_slot());
		end
	endtask

	initial begin
		bit long_done;
		long_done = 1'b0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (!arst_n) begin
				m_tready = 1'b0;
			end else if (hold_long && !long_done) begin
				m_tready = 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
				long_done = 1'b1;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				m_tready = 1'b0;
				repeat ($urandom_range(1, 7) - 1) @(negedge clk);
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("process_id_and_slot_allocator_unit_tb: errors");
			$finish;
		end
	end

	initial begin
		bit hold_done;
		bit pause_done;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		n_sent = 0;
		quiet = 1'b0;
		hold_done = 0;
		pause_done = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		send_item(FN_COMMIT, 6'd5);
		send_item(FN_NONE, 6'd63);
		send_item(FN_ALLOC, 6'd0);
		send_item(FN_COMMIT, 6'd1);
		send_item(FN_COMMIT, 6'd0);
		send_item(FN_ALLOC, 6'd63);
		send_item(FN_COMMIT, 6'd63);
		send_item(FN_COMMIT, 6'd1);
		send_item(FN_ALLOC, 6'd42);
		send_item(FN_COMMIT, 6'd2);
		send_item(FN_RELEASE, 6'd63);
		send_item(FN_RELEASE, 6'd0);
		send_item(FN_RELEASE, 6'd42);
		send_item(FN_RELEASE, 6'd5);
		send_item(FN_ALLOC, 6'd21);
		send_item(FN_NONE, 6'd0);
		send_item(FN_RELEASE, 6'd1);
		send_item(FN_ALLOC, 6'd0);
		send_item(FN_COMMIT, 6'd3);
		send_item(FN_ALLOC, 6'd0);

		while (n_sent < TOTAL_ITEMS) begin
			case ($urandom_range(0, 2))
				0: fill_sweep();
				1: mixed_run();
				default: drain_run();
			endcase
			if (!hold_done && n_sent > 300) begin
				hold_long = 1'b1;
				hold_done = 1;
			end
			if (!pause_done && n_sent > 650) begin
				rest_sender(1);
				wait (pending == 0);
				pause_done = 1;
			end
		end

		rest_sender(1);
		wait (pending == 0);
		repeat (40) @(posedge clk);
		$display("Sent %0d transactions, checked %0d results.", n_sent, results_seen);
		$display("Allocations: %0d, of which %0d found the slot table full.",
			allocs_seen, full_misses);
		if (errors == 0)
			$display("process_id_and_slot_allocator_unit_tb: clean");
		else
			$display("process_id_and_slot_allocator_unit_tb: errors");
		$finish;
	end

endmodule
